// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

   // Character codes of the standard alphabet.
   localparam logic [7:0] PadCode      = 8'd61;
   localparam logic [7:0] UpperFirst   = 8'd65;
   localparam logic [7:0] UpperLast    = 8'd90;
   localparam logic [7:0] LowerFirst   = 8'd97;
   localparam logic [7:0] LowerLast    = 8'd122;
   localparam logic [7:0] DigitFirst   = 8'd48;
   localparam logic [7:0] DigitLast    = 8'd57;
   localparam logic [7:0] PlusCode     = 8'd43;
   localparam logic [7:0] SlashCode    = 8'd47;

   // Offsets that turn a character code into its sextet value.
   localparam logic [7:0] LowerOffset  = 8'd71;
   localparam logic [7:0] DigitOffset  = 8'd4;
   localparam logic [5:0] PlusValue    = 6'd62;
   localparam logic [5:0] SlashValue   = 6'd63;

   // Group geometry.
   localparam logic [1:0] LastPosition = 2'd3;
   localparam logic [1:0] ThirdPosition = 2'd2;
   localparam logic [1:0] GroupBytes   = 2'd3;

   // Default depth of the group queue between front and back.
   localparam int QueueDepthDefault = 4;

   typedef struct packed {
      logic [7:0] char_code;
      logic       final_char;
   } b64d_in_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
      logic       bad_input;
   } b64d_out_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } b64d_sextet_type;

   // One decoded group handed from the front to the back.
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  nbytes;
      logic        fin;
      logic        bad;
   } b64d_cmd_type;

   // Map a character code to its six-bit value and a validity flag.
   function automatic b64d_sextet_type sextet_of(input logic [7:0] ch);
      b64d_sextet_type s;
      s.ok    = 1'b1;
      s.value = 6'd0;
      if (ch >= UpperFirst && ch <= UpperLast) begin
         s.value = 6'(ch - UpperFirst);
      end else if (ch >= LowerFirst && ch <= LowerLast) begin
         s.value = 6'(ch - LowerOffset);
      end else if (ch >= DigitFirst && ch <= DigitLast) begin
         s.value = 6'(ch + DigitOffset);
      end else if (ch == PlusCode) begin
         s.value = PlusValue;
      end else if (ch == SlashCode) begin
         s.value = SlashValue;
      end else if (ch != PadCode) begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== rtl/b64d_cmd_fifo.sv =====
module b64d_cmd_fifo
   import b64d_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64d_cmd_type push_cmd,
   input  logic         pop,
   output b64d_cmd_type head_cmd,
   output logic         empty,
   output logic         full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   b64d_cmd_type        mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntW'(Depth));
   assign head_cmd = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only written entries are ever read.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("group queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("group queue read while empty");

endmodule

// ===== rtl/b64d_front.sv =====
module b64d_front
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  b64d_in_type  req_word,
   input  logic         queue_full,
   output logic         push,
   output b64d_cmd_type push_cmd
);

   logic [17:0]     acc_ff, acc_in;
   logic [1:0]      pos_ff, pos_in;
   logic            pad3_ff, pad3_in;
   logic            err_ff, err_in;
   logic            accept;
   logic            is_pad;
   logic            err_now;
   b64d_sextet_type sx;

   // Stall depends on registered queue state only.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   assign sx      = sextet_of(req_word.char_code);
   assign is_pad  = (req_word.char_code == PadCode);
   assign err_now = err_ff | ~sx.ok;

   // Collect sextets and hand finished groups to the queue.
   always_comb begin
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      pad3_in  = pad3_ff;
      err_in   = err_ff;
      push     = 1'b0;
      push_cmd = '{bits: 24'd0, nbytes: 2'd1, fin: 1'b1, bad: 1'b1};
      if (accept) begin
         if (pos_ff != LastPosition) begin
            if (req_word.final_char) begin
               // A short final group yields one error result.
               push    = 1'b1;
               acc_in  = '0;
               pos_in  = '0;
               pad3_in = 1'b0;
               err_in  = 1'b0;
            end else begin
               acc_in = {acc_ff[11:0], sx.value};
               pos_in = pos_ff + 1'b1;
               err_in = err_now;
               if (pos_ff == ThirdPosition) begin
                  pad3_in = is_pad;
               end
            end
         end else begin
            push            = 1'b1;
            push_cmd.bits   = {acc_ff, sx.value};
            push_cmd.fin    = req_word.final_char;
            push_cmd.bad    = req_word.final_char & err_now;
            push_cmd.nbytes = req_word.final_char
                              ? GroupBytes - {1'b0, is_pad} - {1'b0, pad3_ff}
                              : GroupBytes;
            acc_in  = '0;
            pos_in  = '0;
            pad3_in = 1'b0;
            err_in  = req_word.final_char ? 1'b0 : err_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         pad3_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         pad3_ff <= pad3_in;
         err_ff  <= err_in;
      end
   end

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.final_char |=> pos_ff == '0 && !err_ff && !pad3_ff)
      else $error("group state not cleared after the final character");

   a_push_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> push_cmd.nbytes != 2'd0)
      else $error("group pushed with no bytes");

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_empty,
   input  b64d_cmd_type head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output b64d_out_type rsp_word
);

   logic [1:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   b64d_out_type word_ff, word_in;
   logic         load;
   logic         last;
   logic [7:0]   sel_byte;

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   // The output register takes a new byte when empty or being drained.
   assign load = !queue_empty && (!valid_ff || !rsp_stall);
   assign last = (idx_ff == head_cmd.nbytes - 2'd1);
   assign pop  = load && last;

   // Bytes leave most significant first.
   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_cmd.bits[23:16];
         2'd1:    sel_byte = head_cmd.bits[15:8];
         default: sel_byte = head_cmd.bits[7:0];
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in           = 1'b1;
         word_in.data_byte  = sel_byte;
         word_in.final_byte = head_cmd.fin & last;
         word_in.bad_input  = head_cmd.bad & last;
         idx_in             = last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   a_bad_on_final: assert property (@(posedge clock) disable iff (reset)
      valid_ff && word_ff.bad_input |-> word_ff.final_byte)
      else $error("error flag on a byte that does not end the string");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> idx_ff < head_cmd.nbytes)
      else $error("byte index beyond the group size");

endmodule

// ===== rtl/base64_stream_decoder_top.sv =====
// Base64 stream decoder: one character word accepted per cycle unless the queue is full,
// one byte out per cycle unless stalled. A group enters the queue as its fourth character
// is taken, then its first byte moves to the output register. Four characters yield at most
// three bytes, so the byte side, limited by its single output register, keeps pace.
// Reset (synchronous, active high) clears the group state, the queue and the output valid.
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  b64d_in_type  req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output b64d_out_type rsp_word
);

   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_empty;
   b64d_cmd_type push_cmd;
   b64d_cmd_type head_cmd;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   b64d_cmd_fifo #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   // Tracks the decoder state and holds the bytes it should produce, in order.
   class b64_scoreboard;
      logic [17:0]  acc_bits;
      logic [1:0]   char_pos;
      logic         third_was_pad;
      logic         bad_seen;
      b64d_out_type expected_bytes[$];
      int           mismatches;
      int           bytes_checked;
      int           strings_done;
      int           bad_strings;

      function new();
         clear_string();
         mismatches    = 0;
         bytes_checked = 0;
         strings_done  = 0;
         bad_strings   = 0;
      endfunction

      function void clear_string();
         acc_bits      = '0;
         char_pos      = '0;
         third_was_pad = 1'b0;
         bad_seen      = 1'b0;
      endfunction

      // Six-bit value of a character; ok is low outside the alphabet and padding.
      function void sextet_value(input logic [7:0] ch, output logic [5:0] v, output logic ok);
         ok = 1'b1;
         v  = 6'd0;
         if (ch >= "A" && ch <= "Z") begin
            v = 6'(ch - "A");
         end else if (ch >= "a" && ch <= "z") begin
            v = 6'(ch - "a" + 26);
         end else if (ch >= "0" && ch <= "9") begin
            v = 6'(ch - "0" + 52);
         end else if (ch == "+") begin
            v = 6'd62;
         end else if (ch == "/") begin
            v = 6'd63;
         end else if (ch != PadCode) begin
            ok = 1'b0;
         end
      endfunction

      function void push_byte(logic [7:0] data, logic fin, logic bad);
         b64d_out_type r;
         r.data_byte  = data;
         r.final_byte = fin;
         r.bad_input  = bad;
         expected_bytes.push_back(r);
         if (fin) begin
            strings_done++;
            if (bad) bad_strings++;
         end
      endfunction

      // Called for every character word the decoder accepts.
      function void note_char(b64d_in_type w);
         logic [5:0]  v;
         logic        ok;
         logic        is_pad;
         logic [23:0] group_bits;
         int          count;
         sextet_value(w.char_code, v, ok);
         is_pad = (w.char_code == PadCode);
         if (!ok) bad_seen = 1'b1;
         if (char_pos != LastPosition) begin
            acc_bits = {acc_bits[11:0], v};
            if (char_pos == ThirdPosition) third_was_pad = is_pad;
            char_pos = char_pos + 2'd1;
            // A string that ends inside a group yields a single error byte.
            if (w.final_char) begin
               push_byte(8'd0, 1'b1, 1'b1);
               clear_string();
            end
         end else begin
            group_bits = {acc_bits, v};
            count = 3;
            if (w.final_char) count = 3 - int'(is_pad) - int'(third_was_pad);
            for (int i = 0; i < count; i++) begin
               push_byte(group_bits[23 - 8 * i -: 8], w.final_char && i == count - 1,
                         (w.final_char && i == count - 1) ? bad_seen : 1'b0);
            end
            if (w.final_char) begin
               clear_string();
            end else begin
               acc_bits      = '0;
               char_pos      = '0;
               third_was_pad = 1'b0;
            end
         end
      endfunction

      function void report(string what, b64d_out_type exp_w, b64d_out_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s: expected byte %02h fin %b bad %b, got byte %02h fin %b bad %b",
                     what, exp_w.data_byte, exp_w.final_byte, exp_w.bad_input,
                     got.data_byte, got.final_byte, got.bad_input);
         end
      endfunction

      // Called for every byte word taken from the decoder.
      function void check_byte(b64d_out_type got);
         b64d_out_type exp_w;
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            report("Unexpected byte", '0, got);
            return;
         end
         exp_w = expected_bytes.pop_front();
         if (got.data_byte != exp_w.data_byte) report("Data mismatch", exp_w, got);
         if (got.final_byte != exp_w.final_byte) report("Final flag mismatch", exp_w, got);
         if (got.bad_input != exp_w.bad_input) report("Error flag mismatch", exp_w, got);
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   b64d_in_type  req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   b64d_out_type rsp_word;

   b64_scoreboard sb = new();
   int            chars_sent = 0;
   bit            sender_quiet = 1'b0;
   bit            receiver_quiet = 1'b0;
   int            stall_left = 0;

   base64_stream_decoder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #1 clock = ~clock;

   // Runaway guard.
   initial begin
      #1000000;
      $display("Regression FAIL");
      $finish;
   end

   // Byte side: take words, check them and draw a stall before the next one.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         sb.check_byte(rsp_word);
         if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
         n = receiver_quiet ? 0 : $urandom_range(0, 17);
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (rsp_stall) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   // Offer one character word after a random gap and hold it until it is taken.
   task automatic send_char(b64d_in_type w);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_char(w);
      chars_sent++;
   endtask

   task automatic send_text(string s, bit ends);
      b64d_in_type w;
      for (int i = 0; i < s.len(); i++) begin
         w.char_code  = s[i];
         w.final_char = ends && (i == s.len() - 1);
         send_char(w);
      end
   endtask

   task automatic wait_for_drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] alphabet_char(int idx);
      if (idx < 26) return 8'(UpperFirst + idx);
      if (idx < 52) return 8'(LowerFirst + idx - 26);
      if (idx < 62) return 8'(DigitFirst + idx - 52);
      if (idx == 62) return PlusCode;
      return SlashCode;
   endfunction

   // Mostly well-formed strings with random content; some padded oddly, corrupted or cut short.
   task automatic send_random_string();
      b64d_in_type chars[$];
      b64d_in_type w;
      int          ngroups;
      int          len;
      int          pad_mode;
      int          cut;
      logic [7:0]  c;
      logic [5:0]  v;
      logic        ok;
      ngroups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      len = 4 * ngroups;
      for (int k = 0; k < len; k++) begin
         w.char_code  = alphabet_char($urandom_range(0, 63));
         w.final_char = 1'b0;
         chars.push_back(w);
      end
      pad_mode = $urandom_range(0, 3);
      if (pad_mode == 1 || pad_mode == 2) chars[len - 1].char_code = PadCode;
      if (pad_mode >= 2) chars[len - 2].char_code = PadCode;
      if ($urandom_range(0, 7) == 0) chars[$urandom_range(0, len - 3)].char_code = PadCode;
      if ($urandom_range(0, 7) == 0) begin
         do begin
            c = 8'($urandom_range(0, 255));
            sb.sextet_value(c, v, ok);
         end while (ok);
         chars[$urandom_range(0, len - 1)].char_code = c;
      end
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(1, 3);
         repeat (cut) void'(chars.pop_back());
      end
      chars[chars.size() - 1].final_char = 1'b1;
      foreach (chars[k]) send_char(chars[k]);
   endtask

   // Raw bytes of any value, ended after a few characters.
   task automatic send_noise_string();
      b64d_in_type w;
      int          len;
      len = $urandom_range(1, 9);
      for (int k = 0; k < len; k++) begin
         w.char_code  = 8'($urandom_range(0, 255));
         w.final_char = (k == len - 1);
         send_char(w);
      end
   endtask

   initial begin
      b64d_in_type w;
      int          random_start;
      bit          drained;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Alphabet extremes, padding in the second, third and fourth positions, a pad only in the fourth position.
      send_text("/+9zT=E=09==", 1'b1);
      send_text("QUI=", 1'b1);
      // Invalid codes at both ends of the byte range, then a third-position pad.
      w.final_char = 1'b0;
      w.char_code  = 8'h00;
      send_char(w);
      w.char_code  = 8'hFF;
      send_char(w);
      send_text("=C", 1'b1);
      // Strings that end inside a group.
      send_text("QU", 1'b1);
      send_text("Q", 1'b1);

      random_start = chars_sent;
      while (chars_sent - random_start < 500) begin
         if ($urandom_range(0, 3) == 0) sender_quiet = !sender_quiet;
         if ($urandom_range(0, 9) == 0) begin
            send_noise_string();
         end else begin
            send_random_string();
         end
         // Once mid-run, hold off until the decoder has emitted everything.
         if (!drained && chars_sent - random_start >= 250) begin
            req_valid <= 1'b0;
            wait_for_drain();
            drained = 1'b1;
         end
      end
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("Sent %0d characters forming %0d strings, %0d of them flagged bad.",
               chars_sent, sb.strings_done, sb.bad_strings);
      $display("Checked %0d decoded bytes, %0d mismatches.", sb.bytes_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
